// ===== src/scr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types, opcodes and arithmetic widths of the sensor command responder.
// ----------------------------------------------------------------------------
package scr_pkg;

  // Converter resolution and full-scale code Q = 2^ADC_BITS - 1
  localparam int ADC_BITS = 10;
  localparam int ADC_IN_W = 10;
  localparam int ADC_FULL = (1 << ADC_BITS) - 1;

  // Scale factor: 5 * slope (16 bits) needs 19 bits
  localparam int MULT_W = 19;
  localparam int PROD_W = MULT_W + ADC_BITS;
  // Dividend P + Q/2 rounded down, one bit wider than the product
  localparam int DIV_W = PROD_W + 1;
  // Number of folded digits in the divide-by-Q estimate
  localparam int DIV_TERMS = (DIV_W + ADC_BITS - 1) / ADC_BITS;
  localparam int CORR_W = $clog2(DIV_TERMS + 1);
  localparam int REM_W = ADC_BITS + CORR_W;
  localparam int SUM_W = MULT_W + 1;
  localparam int HALF_M1 = (1 << (ADC_BITS - 1)) - 1;

  // Voltage scale: 5.00 V in hundredths
  localparam int VOLT_SCALE = 500;
  localparam logic [15:0] VALUE_MAX = 16'hFFFF;

  // Command opcodes
  localparam logic [7:0] OP_VOLT  = 8'h56;
  localparam logic [7:0] OP_CURR  = 8'h49;
  localparam logic [7:0] OP_GET_A = 8'h41;
  localparam logic [7:0] OP_GET_B = 8'h42;
  localparam logic [7:0] OP_SET_A = 8'h4E;
  localparam logic [7:0] OP_SET_B = 8'h4D;
  localparam logic [7:0] NEWLINE  = 8'h0A;

  // Byte positions inside a packet and inside a reply
  localparam logic [1:0] POS_OPCODE = 2'd0;
  localparam logic [1:0] POS_VAL_HI = 2'd1;
  localparam logic [1:0] POS_VAL_LO = 2'd2;
  localparam logic [1:0] POS_LAST   = 2'd3;

  typedef struct packed {
    logic [7:0]          rx_byte;
    logic [ADC_IN_W-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       reply_last;
  } out_item_t;

  // Decoded command: reply value = sat(base + round(prod / Q))
  typedef struct packed {
    logic [7:0]        opcode;
    logic [15:0]       base;
    logic [PROD_W-1:0] prod;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [15:0] value;
  } reply_t;

endpackage

// ===== src/scr_assembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_assembler
// Input register, packet gathering, opcode decode, coefficient storage and
// the scale multiply. Emits one decoded command per completed packet with a known opcode.
// ----------------------------------------------------------------------------
module scr_assembler
  import scr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  logic              a_vld_r;
  in_item_t          a_data_r;
  logic [1:0]        byte_count_r, byte_count_nxt;
  logic [7:0]        opcode_hold_r, opcode_hold_nxt;
  logic [15:0]       value_hold_r, value_hold_nxt;
  logic [15:0]       slope_r, slope_nxt;
  logic [15:0]       offset_r, offset_nxt;
  logic              cmd_vld_r;
  cmd_t              cmd_r, cmd_nxt;

  logic              a_reply;
  logic              a_go;
  logic              b_adv;
  logic [MULT_W-1:0] scale;
  logic [ADC_BITS-1:0] adc;

  // Handshake: an item leaves the input register when it needs no slot
  // downstream or when the command register is free
  assign b_adv    = !cmd_vld_r || cmd_ready;
  assign a_go     = a_vld_r && (!a_reply || b_adv);
  assign in_stall = a_vld_r && !a_go;

  assign adc = ADC_BITS'(a_data_r.adc_sample);

  // Gather packet bytes and decode on the terminator
  always_comb begin
    byte_count_nxt  = byte_count_r + 2'd1;
    opcode_hold_nxt = opcode_hold_r;
    value_hold_nxt  = value_hold_r;
    slope_nxt       = slope_r;
    offset_nxt      = offset_r;
    a_reply         = 1'b0;
    scale           = '0;
    cmd_nxt.opcode  = opcode_hold_r;
    cmd_nxt.base    = '0;
    unique case (byte_count_r)
      POS_OPCODE: opcode_hold_nxt = a_data_r.rx_byte;
      POS_VAL_HI: value_hold_nxt[15:8] = a_data_r.rx_byte;
      POS_VAL_LO: value_hold_nxt[7:0] = a_data_r.rx_byte;
      POS_LAST: begin
        unique case (opcode_hold_r)
          OP_VOLT: begin
            a_reply = 1'b1;
            scale   = MULT_W'(VOLT_SCALE);
          end
          OP_CURR: begin
            a_reply      = 1'b1;
            scale        = MULT_W'({slope_r, 2'b00}) + MULT_W'(slope_r);
            cmd_nxt.base = offset_r;
          end
          OP_GET_A: begin
            a_reply      = 1'b1;
            cmd_nxt.base = slope_r;
          end
          OP_GET_B: begin
            a_reply      = 1'b1;
            cmd_nxt.base = offset_r;
          end
          OP_SET_A: begin
            a_reply      = 1'b1;
            slope_nxt    = value_hold_r;
            cmd_nxt.base = value_hold_r;
          end
          OP_SET_B: begin
            a_reply      = 1'b1;
            offset_nxt   = value_hold_r;
            cmd_nxt.base = value_hold_r;
          end
          default: a_reply = 1'b0;
        endcase
      end
      default: a_reply = 1'b0;
    endcase
    cmd_nxt.prod = PROD_W'(scale) * PROD_W'(adc);
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r       <= 1'b0;
      byte_count_r  <= '0;
      opcode_hold_r <= '0;
      value_hold_r  <= '0;
      slope_r       <= '0;
      offset_r      <= '0;
      cmd_vld_r     <= 1'b0;
    end else begin
      if (!in_stall) begin
        a_vld_r <= in_valid;
      end
      if (a_go) begin
        byte_count_r  <= byte_count_nxt;
        opcode_hold_r <= opcode_hold_nxt;
        value_hold_r  <= value_hold_nxt;
        slope_r       <= slope_nxt;
        offset_r      <= offset_nxt;
      end
      if (b_adv) begin
        cmd_vld_r <= a_go && a_reply;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      a_data_r <= in_data;
    end
    if (b_adv) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = cmd_vld_r;
  assign cmd       = cmd_r;

endmodule

// ===== src/scr_divide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_divide
// Rounded divide by the full-scale code Q = 2^ADC_BITS - 1. A folded digit
// sum gives an estimate that is registered; the next step corrects it from
// the remainder, adds the base value and saturates to 16 bits.
// ----------------------------------------------------------------------------
module scr_divide
  import scr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cmd_valid,
  output logic   cmd_ready,
  input  cmd_t   cmd,
  output logic   rep_valid,
  input  logic   rep_ready,
  output reply_t rep
);

  logic              c_vld_r;
  logic [7:0]        c_op_r;
  logic [15:0]       c_base_r;
  logic [DIV_W-1:0]  c_div_r;
  logic [MULT_W-1:0] c_q0_r;

  logic [DIV_W-1:0]  div_in;
  logic [DIV_W-1:0]  q_acc;
  logic [DIV_W-1:0]  rem_full;
  logic [REM_W-1:0]  rem;
  logic [CORR_W-1:0] corr;
  logic [SUM_W-1:0]  total;

  assign cmd_ready = !c_vld_r || rep_ready;

  // Estimate floor(D / Q) as the sum of D shifted by whole digits
  always_comb begin
    div_in = DIV_W'(cmd.prod) + DIV_W'(HALF_M1);
    q_acc  = '0;
    for (int k = 1; k <= DIV_TERMS; k++) begin
      q_acc = q_acc + (div_in >> (k * ADC_BITS));
    end
  end

  // Correct the estimate from the remainder, add base and saturate
  always_comb begin
    rem_full = c_div_r - (DIV_W'(c_q0_r) << ADC_BITS) + DIV_W'(c_q0_r);
    rem      = REM_W'(rem_full);
    corr     = '0;
    for (int j = 1; j <= DIV_TERMS; j++) begin
      if (rem >= REM_W'(j * ADC_FULL)) begin
        corr = corr + CORR_W'(1);
      end
    end
    total = SUM_W'(c_base_r) + SUM_W'(c_q0_r) + SUM_W'(corr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (cmd_ready) begin
      c_vld_r <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready) begin
      c_op_r   <= cmd.opcode;
      c_base_r <= cmd.base;
      c_div_r  <= div_in;
      c_q0_r   <= MULT_W'(q_acc);
    end
  end

  assign rep_valid = c_vld_r;
  assign rep.opcode = c_op_r;
  assign rep.value  = (total > SUM_W'(VALUE_MAX)) ? VALUE_MAX : total[15:0];

endmodule

// ===== src/scr_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scr_serializer
// Reply output register: holds one reply and sends its four bytes in order,
// taking the next reply in the cycle its newline byte leaves.
// ----------------------------------------------------------------------------
module scr_serializer
  import scr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      rep_valid,
  output logic      rep_ready,
  input  reply_t    rep,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic       busy_r;
  logic [1:0] idx_r;
  reply_t     rep_r;

  assign rep_ready = !busy_r || (idx_r == POS_LAST && !out_stall);

  // Load a new reply or advance to the next byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= POS_OPCODE;
    end else if (rep_ready) begin
      busy_r <= rep_valid;
      idx_r  <= POS_OPCODE;
    end else if (!out_stall) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rep_ready && rep_valid) begin
      rep_r <= rep;
    end
  end

  // Select the byte on the output
  always_comb begin
    unique case (idx_r)
      POS_OPCODE: out_data.tx_byte = rep_r.opcode;
      POS_VAL_HI: out_data.tx_byte = rep_r.value[15:8];
      POS_VAL_LO: out_data.tx_byte = rep_r.value[7:0];
      POS_LAST:   out_data.tx_byte = NEWLINE;
      default:    out_data.tx_byte = NEWLINE;
    endcase
    out_data.reply_last = (idx_r == POS_LAST);
  end

  assign out_valid = busy_r;

endmodule

// ===== src/sensor_command_responder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_command_responder_top
// Gathers 4-byte command packets from a serial byte stream and answers each
// known command with a 4-byte reply (opcode, 16-bit value, newline).
// ----------------------------------------------------------------------------
//  channel  | ports                          | payload
//  ---------+--------------------------------+--------------------------------
//  input    | in_valid, in_stall, in_data    | rx_byte[7:0], adc_sample[9:0]
//  result   | out_valid, out_stall, out_data | tx_byte[7:0], reply_last
//
//  One byte is accepted per cycle unless in_stall is high; bytes that do not
//  finish a packet leave the input register at once. A finished packet passes
//  the decode/multiply register, the divide register and the reply output
//  register in that order; the reply then leaves one byte per cycle while
//  out_stall is low, set by the single reply output register, which takes the
//  next reply as the newline byte of the last one leaves. Synchronous active-low reset
//  clears counters, held bytes and coefficients. out_stall holds the current
//  byte and backs up through the pipeline into in_stall.
// ----------------------------------------------------------------------------
module sensor_command_responder_top
  import scr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic   cmd_valid;
  logic   cmd_ready;
  cmd_t   cmd;
  logic   rep_valid;
  logic   rep_ready;
  reply_t rep;

  // Packet gather, decode and scale multiply
  scr_assembler u_assembler (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Rounded divide by full scale and saturation
  scr_divide u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rep_valid (rep_valid),
    .rep_ready (rep_ready),
    .rep       (rep)
  );

  // Reply byte output
  scr_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .rep_valid (rep_valid),
    .rep_ready (rep_ready),
    .rep       (rep),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
